[sv/evs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evs_pkg: shared types and constants of the energy VAD segmenter
// Register map, reset values, verdict codes and the item passed from the
// squaring stage to the run tracker.
// ----------------------------------------------------------------------------
package evs_pkg;

    // Configuration port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int TICK_W    = 32;
    localparam int THR_W     = 31;
    localparam int MIN_W     = 8;
    localparam int COOL_W    = 16;
    localparam int RUN_W     = 8;
    localparam int SQUARE_W  = 32;
    // mag^2 - threshold lies in [-(2^31-1), 2^30]
    localparam int DELTA_W   = 33;

    // Default chunk length limit
    localparam int CHUNK_MAX_DEF = 1024;

    // Saturation point of the voiced run length
    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    // Register indexes (word address paddr[3:2])
    typedef enum logic [1:0] {
        REG_ENERGY_THRESHOLD  = 2'd0,
        REG_MIN_VOICED_CHUNKS = 2'd1,
        REG_COOLDOWN_TICKS    = 2'd2,
        REG_UNUSED            = 2'd3
    } reg_index_t;

    // Reset values
    localparam logic [THR_W-1:0]  THR_RESET  = 31'd90000;
    localparam logic [MIN_W-1:0]  MIN_RESET  = 8'd3;
    localparam logic [COOL_W-1:0] COOL_RESET = 16'd1000;

    // Segment verdicts
    typedef enum logic [1:0] {
        VERDICT_ACCEPTED  = 2'd0,
        VERDICT_TOO_SHORT = 2'd1,
        VERDICT_COOLDOWN  = 2'd2
    } verdict_t;

    // Live configuration
    typedef struct packed {
        logic [THR_W-1:0]  energy_threshold;
        logic [MIN_W-1:0]  min_voiced_chunks;
        logic [COOL_W-1:0] cooldown_ticks;
    } cfg_t;

    // Item after squaring: energy excess of one sample over the threshold
    typedef struct packed {
        logic                      op;
        logic                      chunk_last;
        logic [TICK_W-1:0]         now_ticks;
        logic signed [DELTA_W-1:0] delta;
    } sq_item_t;

endpackage
`default_nettype wire

[sv/evs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evs_if: valid/ready channels of the energy VAD segmenter
// evs_in_if carries audio samples and detection reports, evs_out_if carries
// one chunk report per finished chunk.
// ----------------------------------------------------------------------------
interface evs_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] sample;
    logic               chunk_last;
    logic [31:0]        now_ticks;

    modport source (output valid, op, sample, chunk_last, now_ticks, input ready);
    modport sink   (input valid, op, sample, chunk_last, now_ticks, output ready);
endinterface

interface evs_out_if;
    logic       valid;
    logic       ready;
    logic       voiced;
    logic       segment_end;
    logic [1:0] verdict;
    logic [7:0] segment_chunks;

    modport source (output valid, voiced, segment_end, verdict, segment_chunks,
                    input ready);
    modport sink   (input valid, voiced, segment_end, verdict, segment_chunks,
                    output ready);
endinterface
`default_nettype wire

[sv/evs_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evs_cfg: configuration registers
// APB-style register file holding threshold, minimum run length and
// cooldown. Writes land on the access cycle; reads return the register.
// ----------------------------------------------------------------------------
module evs_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [evs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [evs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [evs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output evs_pkg::cfg_t                       cfg
);
    import evs_pkg::*;

    logic [THR_W-1:0]  thr_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [COOL_W-1:0] cool_reg;
    logic              wr_en;
    reg_index_t        index;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            min_reg  <= MIN_RESET;
            cool_reg <= COOL_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_ENERGY_THRESHOLD:  thr_reg  <= pwdata[THR_W-1:0];
                REG_MIN_VOICED_CHUNKS: min_reg  <= pwdata[MIN_W-1:0];
                REG_COOLDOWN_TICKS:    cool_reg <= pwdata[COOL_W-1:0];
                default:               ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (index)
            REG_ENERGY_THRESHOLD:  prdata = {{(APB_DATA_W-THR_W){1'b0}}, thr_reg};
            REG_MIN_VOICED_CHUNKS: prdata = {{(APB_DATA_W-MIN_W){1'b0}}, min_reg};
            REG_COOLDOWN_TICKS:    prdata = {{(APB_DATA_W-COOL_W){1'b0}}, cool_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.energy_threshold  = thr_reg;
    assign cfg.min_voiced_chunks = min_reg;
    assign cfg.cooldown_ticks    = cool_reg;

endmodule
`default_nettype wire

[sv/evs_sq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evs_sq: input register and squaring stage
// Registers each accepted item, then squares the sample magnitude and
// subtracts the threshold, so the tracker only needs one add per item.
// ----------------------------------------------------------------------------
module evs_sq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    evs_in_if.sink                             samples,
    input  wire logic [evs_pkg::THR_W-1:0]     energy_threshold,
    output evs_pkg::sq_item_t                  item,
    output logic                               item_valid,
    input  wire logic                          item_take
);
    import evs_pkg::*;

    // Input register
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_op_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_last_reg;
    logic [TICK_W-1:0]   s1_now_reg;

    // Squared-item register
    logic                s2_valid_reg, s2_valid_next;
    sq_item_t            s2_item_reg, s2_item_next;

    logic                s1_load;
    logic                s2_load;
    logic [SAMPLE_W-1:0] mag;
    logic [SQUARE_W-1:0] square;

    // Pipeline moves
    assign s2_load       = s1_valid_reg && (!s2_valid_reg || item_take);
    assign samples.ready = !s1_valid_reg || s2_load;
    assign s1_load       = samples.valid && samples.ready;

    assign s1_valid_next = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s2_load ? 1'b1 : (item_take ? 1'b0 : s2_valid_reg);

    // Magnitude: negation in 16 bits maps -32768 onto 0x8000
    assign mag    = s1_sample_reg[SAMPLE_W-1] ? (~s1_sample_reg + 16'd1) : s1_sample_reg;
    assign square = SQUARE_W'(mag) * SQUARE_W'(mag);

    always_comb
    begin
        s2_item_next.op         = s1_op_reg;
        s2_item_next.chunk_last = s1_last_reg;
        s2_item_next.now_ticks  = s1_now_reg;
        s2_item_next.delta      = $signed({1'b0, square})
                                - $signed({2'b00, energy_threshold});
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg     <= samples.op;
            s1_sample_reg <= samples.sample;
            s1_last_reg   <= samples.chunk_last;
            s1_now_reg    <= samples.now_ticks;
        end
        if (s2_load)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign item       = s2_item_reg;
    assign item_valid = s2_valid_reg;

endmodule
`default_nettype wire

[sv/evs_run.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evs_run: chunk accumulator, run tracker and result register
// Keeps the running energy excess of the open chunk, decides voiced at the
// chunk's last sample, tracks voiced runs and grades each ended run.
// ----------------------------------------------------------------------------
module evs_run #(
    parameter int CHUNK_MAX = evs_pkg::CHUNK_MAX_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire evs_pkg::sq_item_t item,
    input  wire logic              item_valid,
    output logic                   item_take,
    input  wire evs_pkg::cfg_t     cfg,
    evs_out_if.source              results
);
    import evs_pkg::*;

    localparam int CNT_W = $clog2(CHUNK_MAX + 1);
    // Holds sum - threshold*count for any chunk up to CHUNK_MAX samples
    localparam int ACC_W = THR_W + CNT_W + 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CHUNK_MAX);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    run_active_reg, run_active_next;
    logic [RUN_W-1:0]        run_len_reg, run_len_next;
    logic [TICK_W-1:0]       det_time_reg, det_time_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    voiced_reg, voiced_next;
    logic                    seg_end_reg, seg_end_next;
    verdict_t                verdict_reg, verdict_next;
    logic [RUN_W-1:0]        chunks_reg, chunks_next;

    logic                    makes_result;
    logic                    out_free;
    logic                    counting;
    logic signed [ACC_W-1:0] delta_ext;
    logic signed [ACC_W-1:0] acc_sum;
    logic                    voiced;
    logic [TICK_W-1:0]       elapsed;

    // Handshake
    assign makes_result = !item.op && item.chunk_last;
    assign out_free     = !out_valid_reg || results.ready;
    assign item_take    = item_valid && (!makes_result || out_free);

    // Accumulate energy excess
    assign counting  = cnt_reg < CNT_LIMIT;
    assign delta_ext = {{(ACC_W-DELTA_W){item.delta[DELTA_W-1]}}, item.delta};
    assign acc_sum   = counting ? (acc_reg + delta_ext) : acc_reg;
    assign voiced    = !acc_sum[ACC_W-1];
    assign elapsed   = item.now_ticks - det_time_reg;

    always_comb
    begin
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        run_active_next = run_active_reg;
        run_len_next    = run_len_reg;
        det_time_next   = det_time_reg;
        voiced_next     = voiced_reg;
        seg_end_next    = seg_end_reg;
        verdict_next    = verdict_reg;
        chunks_next     = chunks_reg;
        out_valid_next  = out_valid_reg && !results.ready;

        if (item_take)
        begin
            if (item.op)
            begin
                // Detection report: start cooldown
                det_time_next = item.now_ticks;
            end
            else if (!item.chunk_last)
            begin
                acc_next = acc_sum;
                cnt_next = counting ? (cnt_reg + 1'b1) : cnt_reg;
            end
            else
            begin
                // Close the chunk and report it
                acc_next       = '0;
                cnt_next       = '0;
                out_valid_next = 1'b1;
                voiced_next    = voiced;
                seg_end_next   = 1'b0;
                verdict_next   = VERDICT_ACCEPTED;
                chunks_next    = '0;
                if (voiced)
                begin
                    run_active_next = 1'b1;
                    if (run_len_reg != RUN_MAX)
                        run_len_next = run_len_reg + 1'b1;
                end
                else if (run_active_reg)
                begin
                    seg_end_next = 1'b1;
                    chunks_next  = run_len_reg;
                    if (run_len_reg < cfg.min_voiced_chunks)
                        verdict_next = VERDICT_TOO_SHORT;
                    else if (elapsed < {{(TICK_W-COOL_W){1'b0}}, cfg.cooldown_ticks})
                        verdict_next = VERDICT_COOLDOWN;
                    else
                        verdict_next = VERDICT_ACCEPTED;
                    run_active_next = 1'b0;
                    run_len_next    = '0;
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cnt_reg        <= '0;
            run_active_reg <= 1'b0;
            run_len_reg    <= '0;
            det_time_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            run_active_reg <= run_active_next;
            run_len_reg    <= run_len_next;
            det_time_reg   <= det_time_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        voiced_reg  <= voiced_next;
        seg_end_reg <= seg_end_next;
        verdict_reg <= verdict_next;
        chunks_reg  <= chunks_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.voiced         = voiced_reg;
    assign results.segment_end    = seg_end_reg;
    assign results.verdict        = verdict_reg;
    assign results.segment_chunks = chunks_reg;

    // A run ends only on an unvoiced chunk
    a_end_unvoiced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && seg_end_reg |-> !voiced_reg)
        else $error("segment end reported on a voiced chunk");

    // Verdict and length are zero outside a segment end
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !seg_end_reg |-> verdict_reg == VERDICT_ACCEPTED
                                          && chunks_reg == '0)
        else $error("segment fields set without segment end");

    // Sample count never passes the chunk limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LIMIT)
        else $error("sample count beyond chunk limit");

    // Run length is nonzero exactly while a run is open
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg == (run_len_reg != '0))
        else $error("run length out of step with run flag");

    // An ended run always carries at least one chunk
    a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && seg_end_reg |-> chunks_reg != '0)
        else $error("segment end with empty run");

endmodule
`default_nettype wire

[sv/energy_vad_segmenter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// energy_vad_segmenter: energy-based voice activity detector and segmenter
// Sums squared samples per chunk, flags voiced chunks and grades each
// finished voiced run as accepted, too short or inside the cooldown.
// ----------------------------------------------------------------------------
// The block takes one item (sample or detection report) every clock cycle
// while the input is not stalled, and returns one report per finished chunk:
// the accept edge of the chunk's last sample loads the input register, then
// the squaring register loads, and then the accumulator and run tracker
// load the result register once it is free. The chunk accumulator's single
// add-and-sign test per item sets the one item per cycle figure. A waiting
// report does not hold back samples of the next chunk; only the next
// chunk-ending item waits for the result register, and the input stalls once
// that item and the one behind it fill the squaring and input registers.
// Configuration is written over the APB port at word addresses 0x0
// (threshold), 0x4 (minimum voiced chunks) and 0x8 (cooldown ticks); the user
// writes it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module energy_vad_segmenter #(
    parameter int CHUNK_MAX = evs_pkg::CHUNK_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    evs_in_if.sink                              samples,
    evs_out_if.source                           results,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [evs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [evs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [evs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import evs_pkg::*;

    cfg_t     cfg;
    sq_item_t sq_item;
    logic     sq_valid;
    logic     sq_take;

    // Register file
    evs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register and squaring
    evs_sq u_sq (
        .clk              (clk),
        .rst_n            (rst_n),
        .samples          (samples),
        .energy_threshold (cfg.energy_threshold),
        .item             (sq_item),
        .item_valid       (sq_valid),
        .item_take        (sq_take)
    );

    // Accumulation, run tracking and results
    evs_run #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_run (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (sq_item),
        .item_valid (sq_valid),
        .item_take  (sq_take),
        .cfg        (cfg),
        .results    (results)
    );

endmodule
`default_nettype wire
